@@ rtl/core/gnh_pkg.sv @@
package gnh_pkg;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } gnh_op_e;

  typedef enum logic [7:0] {
    REG_SAMPLE_SCALE = 8'd0,
    REG_HEIGHT_GAIN  = 8'd1
  } gnh_reg_e;

  localparam logic [23:0] SCALE_RESET = 24'd3277;
  localparam logic [15:0] GAIN_RESET  = 16'd256;
  localparam int          FracW       = 16;
  localparam int          EntryW      = 8;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } gnh_stage_en_t;

  function automatic logic signed [19:0] gnh_grad(logic [7:0] hash,
                                                  logic signed [17:0] x,
                                                  logic signed [17:0] y);
    logic [3:0]         h;
    logic signed [19:0] xe;
    logic signed [19:0] ye;
    logic signed [19:0] u;
    logic signed [19:0] v;
    h  = hash[3:0];
    xe = {{2{x[17]}}, x};
    ye = {{2{y[17]}}, y};
    u  = (h < 4'd8) ? xe : ye;
    if (h < 4'd4) begin
      v = ye;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = xe;
    end else begin
      v = '0;
    end
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  function automatic logic signed [15:0] gnh_sat16(logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] gnh_sat24(logic signed [24:0] v);
    if (v > 25'sd8388607) return 24'sh7fffff;
    if (v < -25'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

@@ rtl/core/gnh_perm_mem.sv @@
module gnh_perm_mem import gnh_pkg::*; #(
  parameter int TABLE_SIZE = 256
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] waddr_i,
  input  logic [EntryW-1:0]             wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] raddr0_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] raddr1_i,
  output logic [EntryW-1:0]             rdata0_o,
  output logic [EntryW-1:0]             rdata1_o
);

  logic [EntryW-1:0] mem_q [TABLE_SIZE];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

@@ rtl/core/gnh_fade.sv @@
module gnh_fade import gnh_pkg::*; (
  input  logic                clk_i,
  input  gnh_stage_en_t       en_i,
  input  logic [FracW-1:0]    t_i,
  output logic [FracW:0]      fade_o
);

  logic [FracW-1:0] t_q;
  logic [FracW:0]   t2_q;
  logic [FracW:0]   t3_q;
  logic [20:0]      poly_q;
  logic [FracW:0]   fade_q;

  logic [32:0] sq;
  logic [33:0] cube;
  logic [20:0] poly_d;
  logic [38:0] prod;
  logic [22:0] fade_full;

  assign sq        = 33'(t_i) * 33'(t_i) + 33'd32768;
  assign cube      = 34'(t2_q) * 34'(t_q) + 34'd32768;
  assign poly_d    = 21'd6 * 21'(t2_q) + 21'd655360 - 21'd15 * 21'(t_q);
  assign prod      = 39'(t3_q) * 39'(poly_q) + 39'd32768;
  assign fade_full = prod[38:16];

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      t_q  <= t_i;
      t2_q <= sq[32:16];
    end
    if (en_i.s3) begin
      t3_q   <= cube[32:16];
      poly_q <= poly_d;
    end
    if (en_i.s4) begin
      fade_q <= (fade_full > 23'd65536) ? 17'd65536 : fade_full[16:0];
    end
  end

  assign fade_o = fade_q;

endmodule

@@ rtl/core/gnh_lerp.sv @@
module gnh_lerp import gnh_pkg::*; (
  input  logic signed [19:0] a_i,
  input  logic signed [19:0] b_i,
  input  logic [FracW:0]     w_i,
  output logic signed [19:0] y_o
);

  logic signed [20:0] diff;
  logic signed [38:0] prod;
  logic signed [38:0] rnd;

  assign diff = {b_i[19], b_i} - {a_i[19], a_i};
  assign prod = 39'(diff) * $signed({22'd0, w_i});
  assign rnd  = (prod + 39'sd32768) >>> 16;
  assign y_o  = a_i + rnd[19:0];

endmodule

@@ rtl/core/gradient_noise_height_sampler_unit.sv @@
// Gradient noise height sampler: 2D improved Perlin noise in fixed point.
// Opcode in s_axis_tuser selects a permutation-table load (no result) or a
// sample (one result of noise Q2.14 and saturated height Q10.14). Load all
// TABLE_SIZE entries before sampling; TABLE_SIZE must be a power of two.
// Throughput is one transaction per cycle unless m_axis_tready stalls the
// pipe, which runs coordinate multiply, three table stages (five replicated
// dual-read table copies), gradient, two blend stages, rounding and gain
// multiply; loads keep order with samples. Configuration writes
// complete at once; the user makes them only while idle (not enforced).
module gradient_noise_height_sampler_unit import gnh_pkg::*; #(
  parameter int TABLE_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // table_index[7:0], table_value[15:8], grid_col[31:16], grid_row[47:32]
  input  logic [47:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // noise_value[15:0], scaled_height[39:16]
  output logic [39:0] m_axis_tdata
);

  localparam int AW = $clog2(TABLE_SIZE);

  logic [23:0] scale_q;
  logic [15:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      gain_q  <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_SAMPLE_SCALE) scale_q <= cfg_data_i;
      if (cfg_index_i == REG_HEIGHT_GAIN)  gain_q  <= cfg_data_i[15:0];
    end
  end

  logic [8:1] v_q;
  logic       vo_q;
  logic [9:1] adv;

  always_comb begin
    adv[9] = !vo_q || m_axis_tready;
    for (int k = 8; k >= 1; k--) adv[k] = !v_q[k] || adv[k+1];
  end
  assign s_axis_tready = adv[1];

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  logic samp1_q, samp2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      vo_q    <= 1'b0;
      samp1_q <= 1'b0;
      samp2_q <= 1'b0;
    end else begin
      if (adv[1]) begin
        v_q[1]  <= s_axis_tvalid;
        samp1_q <= (s_axis_tuser == OP_SAMPLE);
      end
      if (adv[2]) begin
        v_q[2]  <= v_q[1];
        samp2_q <= samp1_q;
      end
      if (adv[3]) v_q[3] <= v_q[2] && samp2_q;
      for (int k = 4; k <= 8; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
      if (adv[9]) vo_q <= v_q[8];
    end
  end

  // Stage 1: coordinate multiply
  logic [39:0]       px, py;
  logic [AW-1:0]     cx1_q, cy1_q, lidx1_q, lidx2_q;
  logic [FracW-1:0]  fx1_q, fy1_q;
  logic [EntryW-1:0] lval1_q, lval2_q;

  assign px = 40'(s_axis_tdata[31:16]) * 40'(scale_q);
  assign py = 40'(s_axis_tdata[47:32]) * 40'(scale_q);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      cx1_q   <= px[FracW +: AW];
      cy1_q   <= py[FracW +: AW];
      fx1_q   <= px[FracW-1:0];
      fy1_q   <= py[FracW-1:0];
      lidx1_q <= AW'(s_axis_tdata[7:0]);
      lval1_q <= s_axis_tdata[15:8];
    end
  end

  // Stage 2: first table level
  logic [EntryW-1:0] p0_2, p1_2;
  logic [AW-1:0]     cy2_q;
  logic [FracW-1:0]  fx2_q, fy2_q, fx3_q, fy3_q, fx4_q, fy4_q;

  gnh_perm_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem_a (
    .clk_i,
    .we_i     (s_accept && (s_axis_tuser == OP_LOAD)),
    .waddr_i  (AW'(s_axis_tdata[7:0])),
    .wdata_i  (s_axis_tdata[15:8]),
    .re_i     (adv[2]),
    .raddr0_i (cx1_q),
    .raddr1_i (cx1_q + AW'(1)),
    .rdata0_o (p0_2),
    .rdata1_o (p1_2)
  );

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      cy2_q   <= cy1_q;
      fx2_q   <= fx1_q;
      fy2_q   <= fy1_q;
      lidx2_q <= lidx1_q;
      lval2_q <= lval1_q;
    end
    if (adv[3]) begin
      fx3_q <= fx2_q;
      fy3_q <= fy2_q;
    end
    if (adv[4]) begin
      fx4_q <= fx3_q;
      fy4_q <= fy3_q;
    end
  end

  // Stage 3: corner row hashes
  logic [AW-1:0]     a2, b2;
  logic [EntryW-1:0] qa0, qa1, qb0, qb1;
  logic              wb, wc;

  assign a2 = AW'(p0_2) + cy2_q;
  assign b2 = AW'(p1_2) + cy2_q;
  assign wb = adv[2] && v_q[1] && !samp1_q;
  assign wc = adv[3] && v_q[2] && !samp2_q;

  gnh_perm_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem_b0 (
    .clk_i, .we_i(wb), .waddr_i(lidx1_q), .wdata_i(lval1_q),
    .re_i(adv[3]), .raddr0_i(a2), .raddr1_i(a2 + AW'(1)),
    .rdata0_o(qa0), .rdata1_o(qa1)
  );

  gnh_perm_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem_b1 (
    .clk_i, .we_i(wb), .waddr_i(lidx1_q), .wdata_i(lval1_q),
    .re_i(adv[3]), .raddr0_i(b2), .raddr1_i(b2 + AW'(1)),
    .rdata0_o(qb0), .rdata1_o(qb1)
  );

  // Stage 4: corner hashes
  logic [EntryW-1:0] haa, hab, hba, hbb;

  gnh_perm_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem_c0 (
    .clk_i, .we_i(wc), .waddr_i(lidx2_q), .wdata_i(lval2_q),
    .re_i(adv[4]), .raddr0_i(AW'(qa0)), .raddr1_i(AW'(qa1)),
    .rdata0_o(haa), .rdata1_o(hab)
  );

  gnh_perm_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem_c1 (
    .clk_i, .we_i(wc), .waddr_i(lidx2_q), .wdata_i(lval2_q),
    .re_i(adv[4]), .raddr0_i(AW'(qb0)), .raddr1_i(AW'(qb1)),
    .rdata0_o(hba), .rdata1_o(hbb)
  );

  gnh_stage_en_t fade_en;
  logic [FracW:0] wu4, wv4;

  assign fade_en = '{s2: adv[2], s3: adv[3], s4: adv[4]};

  gnh_fade u_fade_x (.clk_i, .en_i(fade_en), .t_i(fx1_q), .fade_o(wu4));
  gnh_fade u_fade_y (.clk_i, .en_i(fade_en), .t_i(fy1_q), .fade_o(wv4));

  // Stage 5: gradients
  logic signed [17:0] x0, x1, y0, y1;
  logic signed [19:0] g0_q, g1_q, g2_q, g3_q;
  logic [FracW:0]     wu5_q, wv5_q, wv6_q;

  assign x0 = {2'b00, fx4_q};
  assign x1 = {2'b11, fx4_q};
  assign y0 = {2'b00, fy4_q};
  assign y1 = {2'b11, fy4_q};

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      g0_q  <= gnh_grad(haa, x0, y0);
      g1_q  <= gnh_grad(hba, x1, y0);
      g2_q  <= gnh_grad(hab, x0, y1);
      g3_q  <= gnh_grad(hbb, x1, y1);
      wu5_q <= wu4;
      wv5_q <= wv4;
    end
  end

  // Stage 6 and 7: bilinear blend
  logic signed [19:0] lo_d, hi_d, lo_q, hi_q, n16_d, n16_q;

  gnh_lerp u_lerp_lo (.a_i(g0_q), .b_i(g1_q), .w_i(wu5_q), .y_o(lo_d));
  gnh_lerp u_lerp_hi (.a_i(g2_q), .b_i(g3_q), .w_i(wu5_q), .y_o(hi_d));
  gnh_lerp u_lerp_n  (.a_i(lo_q), .b_i(hi_q), .w_i(wv6_q), .y_o(n16_d));

  logic signed [19:0] n14_r;
  logic signed [15:0] n14_q;

  assign n14_r = (n16_q + 20'sd2) >>> 2;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      wv6_q <= wv5_q;
    end
    if (adv[7]) n16_q <= n16_d;
    if (adv[8]) n14_q <= gnh_sat16(n14_r);
  end

  // Output: gain multiply and saturate
  logic signed [32:0] hprod;
  logic signed [32:0] hrnd;
  logic [39:0]        out_q;

  assign hprod = {{17{n14_q[15]}}, n14_q} * $signed({17'd0, gain_q});
  assign hrnd  = (hprod + 33'sd128) >>> 8;

  always_ff @(posedge clk_i) begin
    if (adv[9]) out_q <= {gnh_sat24(hrnd[24:0]), n14_q};
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import gnh_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  gradient_noise_height_sampler_unit uut (.*);

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic [23:0] height;
    logic [15:0] noise;
  } sample_res_t;

  typedef struct {
    gnh_op_e     op;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [15:0] col;
    logic [15:0] row;
    logic        has_exp;
    sample_res_t exp_res;
  } stim_row_t;

  logic [7:0]  perm_q[256];
  logic [23:0] scale_q;
  logic [15:0] gain_q;
  sample_res_t pending_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          sink_on = 1'b0;

  function automatic longint rnd_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint fade_w(longint t);
    longint t2, t3, poly, f;
    t2 = (t * t + 32768) >> 16;
    t3 = (t2 * t + 32768) >> 16;
    poly = 6 * t2 + 10 * 65536 - 15 * t;
    f = (t3 * poly + 32768) >>> 16;
    return (f > 65536) ? 65536 : f;
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint x, longint y);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : 0);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint w);
    return a + rnd_shift((b - a) * w, 16);
  endfunction

  function automatic sample_res_t height_sample(logic [15:0] col, logic [15:0] row);
    longint px, py, fx, fy, g0, g1, g2, g3, wu, wv, n, h;
    logic [7:0] cx, cy, a, b;
    sample_res_t r;
    px = longint'(col) * scale_q;
    py = longint'(row) * scale_q;
    cx = px[23:16];
    cy = py[23:16];
    fx = px & 16'hffff;
    fy = py & 16'hffff;
    a = perm_q[cx] + cy;
    b = perm_q[8'(cx + 8'd1)] + cy;
    g0 = corner_dot(perm_q[perm_q[a]], fx, fy);
    g1 = corner_dot(perm_q[perm_q[b]], fx - 65536, fy);
    g2 = corner_dot(perm_q[perm_q[8'(a + 8'd1)]], fx, fy - 65536);
    g3 = corner_dot(perm_q[perm_q[8'(b + 8'd1)]], fx - 65536, fy - 65536);
    wu = fade_w(fx);
    wv = fade_w(fy);
    n = lerp_q16(lerp_q16(g0, g1, wu), lerp_q16(g2, g3, wu), wv);
    n = rnd_shift(n, 2);
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    h = rnd_shift(n * gain_q, 8);
    if (h > 8388607) h = 8388607;
    if (h < -8388608) h = -8388608;
    r.noise = n[15:0];
    r.height = h[23:0];
    return r;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 9)) @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(gnh_reg_e idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_SAMPLE_SCALE) scale_q = data;
    else gain_q = data[15:0];
    @(posedge clk_i);
  endtask

  task automatic send_item(stim_row_t s);
    sample_res_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= s.op;
    s_axis_tdata  <= {s.row, s.col, s.val, s.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (s.op == OP_LOAD) begin
      perm_q[s.idx] = s.val;
    end else begin
      r = height_sample(s.col, s.row);
      if (s.has_exp && r != s.exp_res) begin
        $display("%0t directed row mismatch: expected %h actual %h", $time, s.exp_res, r);
        errors++;
      end
      pending_q = {pending_q, r};
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      idle_burst();
    end
  endtask

  task automatic load_perm(bit ident);
    stim_row_t s;
    int p[256];
    int j, t;
    for (int i = 0; i < 256; i++) p[i] = i;
    if (!ident) begin
      for (int i = 255; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = p[i]; p[i] = p[j]; p[j] = t;
      end
    end
    for (int i = 0; i < 256; i++) begin
      s = '{OP_LOAD, 8'(i), 8'(p[i]), 16'($urandom), 16'($urandom), 1'b0, '0};
      send_item(s);
    end
  endtask

  task automatic send_sample(logic [15:0] c, logic [15:0] r);
    stim_row_t s;
    s = '{OP_SAMPLE, 8'($urandom), 8'($urandom), c, r, 1'b0, '0};
    send_item(s);
  endtask

  always @(posedge clk_i) begin
    sample_res_t got, want;
    if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready ||
        cfg_valid_i && cfg_ready_o)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb_top NOT OK");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.noise !== want.noise) begin
          $display("%0t noise_value: expected %h actual %h", $time, want.noise, got.noise);
          errors++;
        end
        if (got.height !== want.height) begin
          $display("%0t scaled_height: expected %h actual %h", $time, want.height, got.height);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!sink_on) m_axis_tready <= 1'b0;
    else if (quiet) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 7) == 0) m_axis_tready <= ~m_axis_tready;
    else if (!m_axis_tready) m_axis_tready <= ($urandom_range(0, 2) == 0);
  end

  stim_row_t dir_tab[] = '{
    '{OP_SAMPLE, 8'h00, 8'h00, 16'd0,     16'd0,     1'b1, '{24'd0, 16'd0}},
    '{OP_SAMPLE, 8'hff, 8'hff, 16'd10,    16'd0,     1'b0, '0},
    '{OP_SAMPLE, 8'h00, 8'h00, 16'd65535, 16'd65535, 1'b0, '0},
    '{OP_SAMPLE, 8'h00, 8'h00, 16'd20,    16'd30,    1'b0, '0},
    '{OP_SAMPLE, 8'h00, 8'h00, 16'd0,     16'd65535, 1'b0, '0},
    '{OP_SAMPLE, 8'h00, 8'h00, 16'd65535, 16'd0,     1'b0, '0},
    '{OP_SAMPLE, 8'h00, 8'h00, 16'd7,     16'd13,    1'b0, '0},
    '{OP_SAMPLE, 8'h00, 8'h00, 16'haaaa,  16'h5555,  1'b0, '0}
  };

  initial begin
    int n;
    scale_q = SCALE_RESET;
    gain_q  = GAIN_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sink_on = 1'b1;
    load_perm(1'b1);
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    s_axis_tvalid <= 1'b0;
    drain();
    write_reg(REG_SAMPLE_SCALE, 24'hffffff);
    write_reg(REG_HEIGHT_GAIN, 24'h00ffff);
    send_sample(16'd1, 16'd1);
    send_sample(16'd65535, 16'd3);
    send_sample(16'd12345, 16'd54321);
    s_axis_tvalid <= 1'b0;
    drain();
    write_reg(REG_SAMPLE_SCALE, 24'd0);
    write_reg(REG_HEIGHT_GAIN, 24'd0);
    send_sample(16'd100, 16'd200);
    s_axis_tvalid <= 1'b0;
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(REG_SAMPLE_SCALE, 24'd3277); write_reg(REG_HEIGHT_GAIN, 24'd256); end
        1: begin write_reg(REG_SAMPLE_SCALE, 24'h018000); write_reg(REG_HEIGHT_GAIN, 24'hffff); end
        2: begin write_reg(REG_SAMPLE_SCALE, 24'($urandom)); write_reg(REG_HEIGHT_GAIN, 24'($urandom_range(0, 65535))); end
        default: begin write_reg(REG_SAMPLE_SCALE, 24'd8192); write_reg(REG_HEIGHT_GAIN, 24'd700); quiet = 1'b1; end
      endcase
      if (ph == 0) load_perm(1'b0);
      n = 0;
      while (n < 75) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item('{OP_LOAD, 8'($urandom), perm_q[8'($urandom)], 16'($urandom),
                      16'($urandom), 1'b0, '0});
        end else begin
          send_sample(16'($urandom), ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom));
          n++;
        end
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
